// ===== rtl/wmpc_pkg.sv =====
// ----------------------------------------------------------------------------
// wmpc_pkg
// Shared types and constants for the min/peak waveform column block.
// ----------------------------------------------------------------------------
`default_nettype none

package wmpc_pkg;

    localparam int DEFAULT_SAMPLE_BITS = 16;

    localparam int ROW_W    = 12;   // screen row, column index
    localparam int COLS_W   = 13;   // column_count register
    localparam int SPC_W    = 16;   // samples_per_column register, sample counter
    localparam int AMP_W    = 16;   // row_gain register
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DATA_W = 16;

    localparam logic [COLS_W-1:0] MAX_COLUMNS = 13'd4096;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COLUMN_COUNT       = 4'd0,
        CFG_SAMPLES_PER_COLUMN = 4'd1,
        CFG_HEIGHT             = 4'd2,
        CFG_ROW_GAIN           = 4'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [COLS_W-1:0] column_count;
        logic [SPC_W-1:0]  samples_per_column;
        logic [ROW_W-1:0]  height;
        logic [AMP_W-1:0]  row_gain;
    } cfg_t;

    // mapped row word passed from the row stage to the column accumulator
    typedef struct packed {
        logic             valid;
        logic [ROW_W-1:0] row;
    } row_word_t;

endpackage

`default_nettype wire

// ===== rtl/waveform_min_peak_columns.sv =====
// ----------------------------------------------------------------------------
// waveform_min_peak_columns
// Min/peak waveform decimation: maps audio samples to screen rows and emits
// the smallest and largest row of each column.
//
// Usage:
//   Sample channel (sample_valid / sample_stall / sample): one word per
//   accepted sample. Result channel (result_valid / result_stall and the
//   column fields): one word each time samples_per_column samples close a
//   column; last_column marks the final column, after which indexing wraps.
//   Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): always
//   ready; write only while no sample is in flight. Unknown indexes are
//   ignored.
//   Throughput: one sample per cycle while sample_stall is low, set by the
//   single multiply-and-clamp row stage and the min/peak compare.
//   A sample that closes a column passes through the input register and
//   the row register; its result word is then loaded into the result
//   register.
//   Reset: counters, running min/peak and all valids clear; registers take
//   column_count 1, samples_per_column 1, height 0, row_gain 0.
//   A stalled result holds; samples keep flowing into the pipeline until a
//   second completed column has nowhere to go, then sample_stall rises.
// ----------------------------------------------------------------------------
`default_nettype none

module waveform_min_peak_columns #(
    parameter int SAMPLE_BITS = wmpc_pkg::DEFAULT_SAMPLE_BITS
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              sample_valid,
    output logic                             sample_stall,
    input  wire  [SAMPLE_BITS-1:0]           sample,
    output logic                             result_valid,
    input  wire                              result_stall,
    output logic [wmpc_pkg::ROW_W-1:0]       column_index,
    output logic [wmpc_pkg::ROW_W-1:0]       column_min,
    output logic [wmpc_pkg::ROW_W-1:0]       column_peak,
    output logic                             last_column,
    input  wire                              cfg_valid,
    output logic                             cfg_ready,
    input  wire  [wmpc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire  [wmpc_pkg::CFG_DATA_W-1:0]  cfg_data
);

    wmpc_pkg::cfg_t      cfg_reg;
    wmpc_pkg::row_word_t row_word;
    logic                row_ready;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.column_count       <= wmpc_pkg::COLS_W'(1);
            cfg_reg.samples_per_column <= wmpc_pkg::SPC_W'(1);
            cfg_reg.height             <= '0;
            cfg_reg.row_gain           <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (wmpc_pkg::cfg_reg_t'(cfg_index))
                wmpc_pkg::CFG_COLUMN_COUNT:
                    cfg_reg.column_count <= cfg_data[wmpc_pkg::COLS_W-1:0];
                wmpc_pkg::CFG_SAMPLES_PER_COLUMN:
                    cfg_reg.samples_per_column <= cfg_data[wmpc_pkg::SPC_W-1:0];
                wmpc_pkg::CFG_HEIGHT:
                    cfg_reg.height <= cfg_data[wmpc_pkg::ROW_W-1:0];
                wmpc_pkg::CFG_ROW_GAIN:
                    cfg_reg.row_gain <= cfg_data[wmpc_pkg::AMP_W-1:0];
                default:
                    ;
            endcase
        end
    end

    wmpc_row_stage #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_row_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .row_word     (row_word),
        .row_ready    (row_ready)
    );

    wmpc_column_acc u_column_acc (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .row_word     (row_word),
        .row_ready    (row_ready),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .column_index (column_index),
        .column_min   (column_min),
        .column_peak  (column_peak),
        .last_column  (last_column)
    );

    // min never exceeds peak within a column
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (column_min <= column_peak))
        else $error("column_min above column_peak");

    // a column that is not the last must lie below the configured count
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !last_column && cfg_reg.column_count != '0)
            |-> ((wmpc_pkg::COLS_W'(column_index) + wmpc_pkg::COLS_W'(1))
                 < cfg_reg.column_count))
        else $error("non-last column at or past column_count");

    // a stalled result word holds until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall)
            |=> (result_valid && $stable(column_index) && $stable(column_min)
                 && $stable(column_peak) && $stable(last_column)))
        else $error("stalled result word changed");

endmodule

`default_nettype wire

// ===== rtl/wmpc_row_stage.sv =====
// ----------------------------------------------------------------------------
// wmpc_row_stage
// Input register, then sample-to-row mapping (scale, offset, clamp) into a
// row register. Each register advances independently so bubbles collapse.
// ----------------------------------------------------------------------------
`default_nettype none

module wmpc_row_stage #(
    parameter int SAMPLE_BITS = wmpc_pkg::DEFAULT_SAMPLE_BITS
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire wmpc_pkg::cfg_t          cfg,
    input  wire                          sample_valid,
    output logic                         sample_stall,
    input  wire  [SAMPLE_BITS-1:0]       sample,
    output wmpc_pkg::row_word_t          row_word,
    input  wire                          row_ready
);

    localparam int AMP_W  = wmpc_pkg::AMP_W;
    localparam int ROW_W  = wmpc_pkg::ROW_W;
    localparam int PROD_W = SAMPLE_BITS + AMP_W;
    localparam int Q_W    = PROD_W - (SAMPLE_BITS - 1);
    localparam int SUM_W  = Q_W + 2;

    logic                   s1_valid_reg;
    logic [SAMPLE_BITS-1:0] s1_sample_reg;
    logic                   s2_valid_reg;
    logic [ROW_W-1:0]       s2_row_reg;

    logic                   s1_ready;
    logic                   s2_ready;
    logic                   neg;
    logic [SAMPLE_BITS-1:0] mag;
    logic [PROD_W-1:0]      prod;
    logic [Q_W-1:0]         q;
    logic signed [SUM_W-1:0] half_h;
    logic signed [SUM_W-1:0] row_sum;
    logic signed [SUM_W-1:0] ceiling;
    logic [ROW_W-1:0]       row_next;

    assign s2_ready     = !s2_valid_reg || row_ready;
    assign s1_ready     = !s1_valid_reg || s2_ready;
    assign sample_stall = !s1_ready;

    // magnitude of the most negative sample fits unsigned in SAMPLE_BITS
    always_comb
    begin
        neg     = s1_sample_reg[SAMPLE_BITS-1];
        mag     = neg ? (~s1_sample_reg + SAMPLE_BITS'(1)) : s1_sample_reg;
        prod    = PROD_W'(mag) * PROD_W'(cfg.row_gain);
        q       = prod[PROD_W-1:SAMPLE_BITS-1];
        half_h  = $signed(SUM_W'(cfg.height[ROW_W-1:1]));
        ceiling = $signed(SUM_W'(cfg.height));
        row_sum = neg ? (half_h + $signed(SUM_W'(q))) : (half_h - $signed(SUM_W'(q)));
        priority if (row_sum > ceiling)
            row_next = cfg.height;
        else if (row_sum < $signed(SUM_W'(0)))
            row_next = '0;
        else
            row_next = row_sum[ROW_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
                s1_valid_reg <= sample_valid;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && sample_valid)
            s1_sample_reg <= sample;
        if (s2_ready && s1_valid_reg)
            s2_row_reg <= row_next;
    end

    assign row_word.valid = s2_valid_reg;
    assign row_word.row   = s2_row_reg;

endmodule

`default_nettype wire

// ===== rtl/wmpc_column_acc.sv =====
// ----------------------------------------------------------------------------
// wmpc_column_acc
// Folds mapped rows into a running min and peak per column and loads the
// result register when a column completes.
// ----------------------------------------------------------------------------
`default_nettype none

module wmpc_column_acc (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire wmpc_pkg::cfg_t          cfg,
    input  wire wmpc_pkg::row_word_t     row_word,
    output logic                         row_ready,
    output logic                         result_valid,
    input  wire                          result_stall,
    output logic [wmpc_pkg::ROW_W-1:0]   column_index,
    output logic [wmpc_pkg::ROW_W-1:0]   column_min,
    output logic [wmpc_pkg::ROW_W-1:0]   column_peak,
    output logic                         last_column
);

    localparam int ROW_W  = wmpc_pkg::ROW_W;
    localparam int SPC_W  = wmpc_pkg::SPC_W;
    localparam int COLS_W = wmpc_pkg::COLS_W;

    logic [SPC_W-1:0] sample_counter_reg;
    logic [ROW_W-1:0] column_counter_reg;
    logic [ROW_W-1:0] running_min_reg;
    logic [ROW_W-1:0] running_peak_reg;
    logic             result_valid_reg;
    logic [ROW_W-1:0] column_index_reg;
    logic [ROW_W-1:0] column_min_reg;
    logic [ROW_W-1:0] column_peak_reg;
    logic             last_column_reg;

    logic [SPC_W-1:0]  spc_eff;
    logic [COLS_W-1:0] cols_eff;
    logic              first;
    logic              done;
    logic              last;
    logic              out_ready;
    logic              take;
    logic [ROW_W-1:0]  min_next;
    logic [ROW_W-1:0]  peak_next;

    always_comb
    begin
        spc_eff = (cfg.samples_per_column == '0) ? SPC_W'(1) : cfg.samples_per_column;
        priority if (cfg.column_count == '0)
            cols_eff = COLS_W'(1);
        else if (cfg.column_count > wmpc_pkg::MAX_COLUMNS)
            cols_eff = wmpc_pkg::MAX_COLUMNS;
        else
            cols_eff = cfg.column_count;

        first = (sample_counter_reg == '0);
        done  = ((SPC_W + 1)'(sample_counter_reg) + (SPC_W + 1)'(1)) >= (SPC_W + 1)'(spc_eff);
        last  = (COLS_W'(column_counter_reg) + COLS_W'(1)) >= cols_eff;

        // first sample of a column overrides the start values
        min_next  = (first || row_word.row < running_min_reg) ? row_word.row : running_min_reg;
        peak_next = (first || row_word.row > running_peak_reg) ? row_word.row : running_peak_reg;

        out_ready = !result_valid_reg || !result_stall;
        take      = row_word.valid && (!done || out_ready);
    end

    assign row_ready = !row_word.valid || take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_counter_reg <= '0;
            column_counter_reg <= '0;
            running_min_reg    <= '0;
            running_peak_reg   <= '0;
            result_valid_reg   <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                if (done)
                begin
                    sample_counter_reg <= '0;
                    column_counter_reg <= last ? '0 : column_counter_reg + ROW_W'(1);
                    running_min_reg    <= cfg.height;
                    running_peak_reg   <= '0;
                end
                else
                begin
                    sample_counter_reg <= sample_counter_reg + SPC_W'(1);
                    running_min_reg    <= min_next;
                    running_peak_reg   <= peak_next;
                end
            end

            if (take && done)
                result_valid_reg <= 1'b1;
            else if (!result_stall)
                result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && done)
        begin
            column_index_reg <= column_counter_reg;
            column_min_reg   <= min_next;
            column_peak_reg  <= peak_next;
            last_column_reg  <= last;
        end
    end

    assign result_valid = result_valid_reg;
    assign column_index = column_index_reg;
    assign column_min   = column_min_reg;
    assign column_peak  = column_peak_reg;
    assign last_column  = last_column_reg;

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for waveform_min_peak_columns. Streams audio sample
// words through the block in bursts while the result side stalls on shifting
// patterns. It also holds off the result side once for a long stretch so that
// the block backs up. A scoreboard class tracks the registers and the column
// state, computes the row of every accepted sample and the column each
// closing sample yields, and checks every result word against it in order.
// ----------------------------------------------------------------------------

module tb;

    localparam int SAMPLE_BITS   = wmpc_pkg::DEFAULT_SAMPLE_BITS;
    localparam int ROW_W         = wmpc_pkg::ROW_W;
    localparam int COLS_W        = wmpc_pkg::COLS_W;
    localparam int SPC_W         = wmpc_pkg::SPC_W;
    localparam int AMP_W         = wmpc_pkg::AMP_W;
    localparam int CFG_IDX_W     = wmpc_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W    = wmpc_pkg::CFG_DATA_W;
    localparam logic [COLS_W-1:0] MAX_COLUMNS = wmpc_pkg::MAX_COLUMNS;
    localparam int TOTAL_ITEMS   = 1100;
    localparam int SETTLE_CYCLES = 8;       // pipeline: input, row and result registers
    localparam int HOLD_CYCLES   = 300;
    localparam int CYCLE_LIMIT   = 400000;

    localparam logic [CFG_IDX_W-1:0] UNUSED_INDEX_LO =
        CFG_IDX_W'(wmpc_pkg::CFG_ROW_GAIN + 1);
    localparam logic [CFG_IDX_W-1:0] UNUSED_INDEX_HI = '1;

    typedef enum {SINK_FREE, SINK_LIGHT, SINK_HEAVY, SINK_PERIODIC} sink_mode_t;

    typedef struct packed {
        logic [ROW_W-1:0] index;
        logic [ROW_W-1:0] lo;
        logic [ROW_W-1:0] hi;
        logic             last;
    } column_t;

    class column_tracker;
        logic [COLS_W-1:0] column_count_reg;
        logic [SPC_W-1:0]  spc_reg;
        logic [ROW_W-1:0]  height_reg;
        logic [AMP_W-1:0]  amp_reg;
        int unsigned       fill;
        logic [ROW_W-1:0]  column_pos;
        logic [ROW_W-1:0]  run_lo;
        logic [ROW_W-1:0]  run_hi;
        column_t           expected_columns[$];
        int                errors;

        function new();
            column_count_reg = 1;
            spc_reg          = 1;
            height_reg       = 0;
            amp_reg          = 0;
            fill             = 0;
            column_pos       = 0;
            run_lo           = 0;
            run_hi           = 0;
            errors           = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                wmpc_pkg::CFG_COLUMN_COUNT:       column_count_reg = data[COLS_W-1:0];
                wmpc_pkg::CFG_SAMPLES_PER_COLUMN: spc_reg = data[SPC_W-1:0];
                wmpc_pkg::CFG_HEIGHT:             height_reg = data[ROW_W-1:0];
                wmpc_pkg::CFG_ROW_GAIN:           amp_reg = data[AMP_W-1:0];
                default: ;
            endcase
        endfunction

        // height/2 minus the scaled sample, truncated toward zero, clamped
        function logic [ROW_W-1:0] screen_row(logic [SAMPLE_BITS-1:0] raw);
            logic   neg;
            longint mag;
            longint q;
            longint row;
            neg = raw[SAMPLE_BITS-1];
            mag = neg ? ((longint'(1) << SAMPLE_BITS) - longint'(raw)) : longint'(raw);
            q   = (mag * longint'(amp_reg)) >>> (SAMPLE_BITS - 1);
            row = longint'(height_reg >> 1);
            row = neg ? row + q : row - q;
            if (row > longint'(height_reg))
                row = longint'(height_reg);
            if (row < 0)
                row = 0;
            return row[ROW_W-1:0];
        endfunction

        function void note_sample(logic [SAMPLE_BITS-1:0] raw);
            logic [ROW_W-1:0] row;
            int unsigned      spc;
            int unsigned      cols;
            column_t          col;
            row  = screen_row(raw);
            spc  = (spc_reg == 0) ? 1 : spc_reg;
            cols = (column_count_reg == 0) ? 1 : column_count_reg;
            if (cols > MAX_COLUMNS)
                cols = MAX_COLUMNS;
            if (fill == 0)
            begin
                run_lo = row;
                run_hi = row;
            end
            else
            begin
                if (row < run_lo)
                    run_lo = row;
                if (row > run_hi)
                    run_hi = row;
            end
            if (fill + 1 < spc)
            begin
                fill = (fill + 1) & 32'hFFFF;
                return;
            end
            col.index = column_pos;
            col.lo    = run_lo;
            col.hi    = run_hi;
            col.last  = (int'(column_pos) + 1 >= cols);
            expected_columns.push_back(col);
            fill       = 0;
            column_pos = col.last ? '0 : column_pos + 1'b1;
        endfunction

        function void check_column(logic [ROW_W-1:0] idx, logic [ROW_W-1:0] lo,
                                   logic [ROW_W-1:0] hi, logic last);
            column_t want;
            if (expected_columns.size() == 0)
            begin
                $display("%0t: unexpected column word index %0d min %0d peak %0d last %0b",
                         $time, idx, lo, hi, last);
                errors++;
                return;
            end
            want = expected_columns.pop_front();
            if (idx !== want.index)
            begin
                $display("%0t: column_index expected %0d actual %0d", $time, want.index, idx);
                errors++;
            end
            if (lo !== want.lo)
            begin
                $display("%0t: column_min expected %0d actual %0d", $time, want.lo, lo);
                errors++;
            end
            if (hi !== want.hi)
            begin
                $display("%0t: column_peak expected %0d actual %0d", $time, want.hi, hi);
                errors++;
            end
            if (last !== want.last)
            begin
                $display("%0t: last_column expected %0b actual %0b", $time, want.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   sample_valid;
    logic                   sample_stall;
    logic [SAMPLE_BITS-1:0] sample;
    logic                   result_valid;
    logic                   result_stall;
    logic [ROW_W-1:0]       column_index;
    logic [ROW_W-1:0]       column_min;
    logic [ROW_W-1:0]       column_peak;
    logic                   last_column;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    column_tracker tracker;
    int unsigned   items_sent;
    int unsigned   cycle_count;
    bit            hold_request;

    logic [SAMPLE_BITS-1:0] corner_samples [6] =
        '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001, 16'h4000};

    waveform_min_peak_columns #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .column_index (column_index),
        .column_min   (column_min),
        .column_peak  (column_peak),
        .last_column  (last_column),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // observe all three channels on the same edge the block does
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                tracker.write_reg(cfg_index, cfg_data);
            if (sample_valid && !sample_stall)
                tracker.note_sample(sample);
            if (result_valid && !result_stall)
                tracker.check_column(column_index, column_min, column_peak, last_column);
        end
    end

    initial
    begin : result_sink
        sink_mode_t mode;
        int         mode_left;
        int         hold_left;
        int         tick;
        mode      = SINK_FREE;
        mode_left = 0;
        hold_left = 0;
        tick      = 0;
        result_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            tick++;
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = sink_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(40, 200);
                end
                mode_left--;
                case (mode)
                    SINK_FREE:  result_stall <= 1'b0;
                    SINK_LIGHT: result_stall <= ($urandom_range(0, 3) == 0);
                    SINK_HEAVY: result_stall <= ($urandom_range(0, 3) != 0);
                    default:    result_stall <= ((tick % 7) < 3);
                endcase
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(input logic [CFG_DATA_W-1:0] cols,
                              input logic [CFG_DATA_W-1:0] spc,
                              input logic [CFG_DATA_W-1:0] h,
                              input logic [CFG_DATA_W-1:0] amp);
        write_reg(wmpc_pkg::CFG_COLUMN_COUNT, cols);
        write_reg(wmpc_pkg::CFG_SAMPLES_PER_COLUMN, spc);
        write_reg(wmpc_pkg::CFG_HEIGHT, h);
        write_reg(wmpc_pkg::CFG_ROW_GAIN, amp);
    endtask

    task automatic random_config();
        logic [CFG_DATA_W-1:0] cols;
        logic [CFG_DATA_W-1:0] spc;
        logic [CFG_DATA_W-1:0] h;
        logic [CFG_DATA_W-1:0] amp;
        case ($urandom_range(0, 7))
            0:       cols = 0;
            1:       cols = CFG_DATA_W'(MAX_COLUMNS);
            2:       cols = CFG_DATA_W'($urandom);
            3:       cols = 1;
            default: cols = CFG_DATA_W'($urandom_range(2, 6));
        endcase
        case ($urandom_range(0, 9))
            0:       spc = 0;
            1:       spc = 1;
            2:       spc = CFG_DATA_W'($urandom_range(9, 40));
            default: spc = CFG_DATA_W'($urandom_range(1, 6));
        endcase
        case ($urandom_range(0, 5))
            0:       h = 0;
            1:       h = 4095;
            2:       h = CFG_DATA_W'($urandom);     // bits above the register are dropped
            default: h = CFG_DATA_W'($urandom_range(1, 4095));
        endcase
        case ($urandom_range(0, 5))
            0:       amp = 0;
            1:       amp = 16'hFFFF;
            2:       amp = CFG_DATA_W'($urandom);
            default: amp = CFG_DATA_W'(((h[ROW_W-1:0] >> 1) * $urandom_range(1, 4)) / 2);
        endcase
        set_config(cols, spc, h, amp);
        if ($urandom_range(0, 3) == 0)
            write_reg(CFG_IDX_W'($urandom_range(UNUSED_INDEX_HI, UNUSED_INDEX_LO)),
                      CFG_DATA_W'($urandom));
    endtask

    function automatic logic [SAMPLE_BITS-1:0] pick_sample();
        logic [SAMPLE_BITS-1:0] s;
        case ($urandom_range(0, 9))
            0:       s = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            1:       s = SAMPLE_BITS'($urandom_range(0, 128) - 64);
            2:       s = SAMPLE_BITS'($urandom_range(0, 1) ? $urandom_range(30000, 32767)
                                                           : -$urandom_range(30000, 32768));
            default: s = SAMPLE_BITS'($urandom);
        endcase
        return s;
    endfunction

    task automatic send_sample(input logic [SAMPLE_BITS-1:0] value);
        sample_valid <= 1'b1;
        sample       <= value;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic pause(input int cycles);
        sample_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic stream_samples(input int count, input bit gappy);
        int left;
        int burst;
        left = count;
        while (left > 0)
        begin
            burst = $urandom_range(1, 16);
            if (burst > left)
                burst = left;
            repeat (burst) send_sample(pick_sample());
            left -= burst;
            if (gappy && $urandom_range(0, 2) != 0)
                pause($urandom_range(1, 6));
        end
        pause(1);
    endtask

    // no config write may overlap a word still in the pipeline
    task automatic settle();
        while (tracker.expected_columns.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int  phase;
        bit  pressure_done;
        tracker       = new();
        items_sent    = 0;
        cycle_count   = 0;
        hold_request  = 1'b0;
        pressure_done = 1'b0;
        rst_n        <= 1'b0;
        sample_valid <= 1'b0;
        sample       <= '0;
        cfg_valid    <= 1'b0;
        cfg_index    <= '0;
        cfg_data     <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // registers at reset values: zero height, one column of one sample
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        pause(1);
        settle();

        // full scale, wrapping after three columns
        set_config(3, 1, 4095, 16'hFFFF);
        foreach (corner_samples[i])
            send_sample(corner_samples[i]);
        pause(1);
        settle();

        // zero column count and zero samples per column both act as one
        set_config(0, 0, 100, 50);
        send_sample(16'h0100);
        send_sample(16'hFF00);
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        pause(1);
        settle();

        // column count above the maximum, odd height, first sample loads min/peak
        set_config(8191, 3, 1, 1);
        repeat (6) send_sample(pick_sample());
        pause(1);
        settle();

        // shrink samples per column in the middle of a column
        set_config(2, 5, 4094, 16'h8000);
        repeat (3) send_sample(pick_sample());
        pause(1);
        settle();
        write_reg(wmpc_pkg::CFG_SAMPLES_PER_COLUMN, 2);
        write_reg(UNUSED_INDEX_HI, 16'hFFFF);
        repeat (2) send_sample(pick_sample());
        pause(1);
        settle();

        phase = 0;
        while (items_sent < TOTAL_ITEMS)
        begin
            if (phase == 0)
            begin
                // longest column: only a partial fill, closed by the next phase
                set_config(1, 16'hFFFF, 4095, 2047);
                stream_samples(15, 1'b1);
            end
            else if (phase == 1)
            begin
                set_config(CFG_DATA_W'(MAX_COLUMNS), 1, 4095, 16'hFFFF);
                stream_samples($urandom_range(20, 60), 1'b0);
            end
            else if (!pressure_done && items_sent > 400)
            begin
                // one column per sample while the result side holds off
                set_config(3, 1, CFG_DATA_W'($urandom_range(0, 4095)),
                           CFG_DATA_W'($urandom));
                hold_request  = 1'b1;
                pressure_done = 1'b1;
                stream_samples(300, 1'b0);
            end
            else
            begin
                random_config();
                stream_samples($urandom_range(10, 60), $urandom_range(0, 3) != 0);
            end
            settle();
            phase++;
        end

        settle();
        if (tracker.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
